/* src/swts_pkg.sv */
package swts_pkg;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam int STATUS_BITS = 2;
  localparam int POS_BITS    = 10;
  localparam int TOTAL_BITS  = 10;
  localparam int KEPT_BITS   = 9;
  localparam int SUM_BITS    = 25;
  localparam int SQ_BITS     = 41;

  // Per-cell decision for one operation, broadcast from the controller.
  typedef struct packed {
    logic       ins;   // shift right / write new value
    logic       del;   // shift left
  } swts_cmd_t;

endpackage

/* src/sorted_window_trimmed_stats.sv */
// Channel | ports                                   | handshake
// input   | in_opcode, in_value                     | start & !busy
// result  | out_status .. out_trimmed_square_sum    | out_strobe, one cycle
// An item holds busy through S_UPD, where the cell row updates, S_ROT,
// a full rotation of the row over the entries left after the operation,
// feeding the squaring accumulator, the flush states S_FL1 and S_FL2, and
// the result state S_OUT. busy drops in the cycle after the strobe, so a
// new item is taken only once the result of the last one is out.
// Reset is synchronous and empties the row. Results cannot be stalled.
module sorted_window_trimmed_stats #(
  parameter int CAPACITY   = 512,
  parameter int VALUE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_opcode,
  input  logic [VALUE_BITS-1:0]                in_value,
  output logic                                 out_strobe,
  output logic [swts_pkg::STATUS_BITS-1:0]     out_status,
  output logic [swts_pkg::POS_BITS-1:0]        out_position,
  output logic [swts_pkg::TOTAL_BITS-1:0]      out_entry_total,
  output logic [swts_pkg::KEPT_BITS-1:0]       out_kept_total,
  output logic [swts_pkg::SUM_BITS-1:0]        out_trimmed_sum,
  output logic [swts_pkg::SQ_BITS-1:0]         out_trimmed_square_sum
);
  localparam int CB = $clog2(CAPACITY + 1);
  localparam int IB = $clog2(CAPACITY);
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam logic [2:0] S_IDLE = 3'd0, S_UPD = 3'd1, S_ROT = 3'd2,
                         S_FL1 = 3'd3, S_FL2 = 3'd4, S_OUT = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [CB-1:0]         count_r, count_nxt;
  logic [CB-1:0]         step_r;
  logic [CB-1:0]         lo_r, hi_r;
  logic                  op_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [1:0]            status_r;
  logic [CB-1:0]         pos_r;

  logic [VALUE_BITS-1:0] cval [CAPACITY];
  logic                  cvld [CAPACITY];
  logic [VALUE_BITS-1:0] csum [CAPACITY];
  logic [CAPACITY-1:0]   ins_mark, del_mark;
  swts_pkg::swts_cmd_t   cmd;
  logic                  rot;

  // Insert marks valid slots strictly greater plus the first empty slot;
  // delete marks from the first equal slot onward (prefix OR over slots).
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ins_mark[k] = (cvld[k] && cval[k] > val_r) ||
                    (!cvld[k] && (k == 0 || cvld[(k == 0) ? 0 : k - 1]));
      del_mark[k] = cvld[k] && cval[k] == val_r;
    end
  end

  logic [CAPACITY-1:0] ins_pre, del_pre;
  logic [CB-1:0]       ins_pos, del_pos;
  logic                del_hit;
  always_comb begin
    ins_pos = count_r;
    del_pos = '0;
    del_hit = 1'b0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (ins_mark[k]) ins_pos = CB'(k);
      if (del_mark[k]) begin
        del_pos = CB'(k);
        del_hit = 1'b1;
      end
    end
    // An insert only moves slots up to the first empty one.
    for (int k = 0; k < CAPACITY; k++) begin
      ins_pre[k] = CB'(k) >= ins_pos && CB'(k) <= count_r;
      del_pre[k] = del_hit && CB'(k) >= del_pos;
    end
  end

  logic full;
  assign full = count_r == CB'(CAPACITY);

  always_comb begin
    cmd.ins = state_r == S_UPD && op_r == swts_pkg::OP_INSERT && !full;
    cmd.del = state_r == S_UPD && op_r == swts_pkg::OP_DELETE && del_hit;
  end
  assign rot = state_r == S_ROT;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] lv, rv;
    logic                  lm, rvl, mk;
    swts_pkg::swts_cmd_t   c;
    if (g == 0) begin : g_l
      assign lv = '0;
      assign lm = 1'b0;
    end else begin : g_l
      assign lv = cval[g-1];
      assign lm = ins_pre[g-1];
    end
    if (g == CAPACITY - 1) begin : g_r
      assign rv  = rot ? cval[0] : '0;
      assign rvl = rot ? cvld[0] : 1'b0;
    end else begin : g_r
      assign rv  = cval[g+1];
      assign rvl = cvld[g+1];
    end
    // During the rotation every slot shifts left; slot count-1 wraps head.
    always_comb begin
      c.ins = cmd.ins;
      c.del = cmd.del || rot;
      mk    = rot ? 1'b1 : (cmd.ins ? ins_pre[g] : del_pre[g]);
    end
    logic [VALUE_BITS-1:0] wrap_v;
    assign wrap_v = (rot && CB'(g + 1) == count_r) ? cval[0] : rv;
    logic                  wrap_ok;
    assign wrap_ok = rot ? cvld[g] : rvl;
    swts_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(c), .op_value(val_r),
      .left_value(lv), .left_mark(lm), .right_value(wrap_v),
      .right_valid(wrap_ok), .mark(mk), .sum_en(1'b0), .sum_in(rv),
      .value_r(cval[g]), .valid_r(cvld[g]), .sum_out(csum[g])
    );
  end

  logic take;
  assign take = rot && step_r >= lo_r && step_r < hi_r;

  swts_stats #(.VALUE_BITS(VALUE_BITS)) u_stats (
    .clk(clk), .clear(state_r == S_UPD), .take(take), .head(csum[0]),
    .sum_r(out_trimmed_sum), .sq_r(out_trimmed_square_sum)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_UPD;
      S_UPD: begin
        state_nxt = S_ROT;
        if (cmd.ins) count_nxt = count_r + 1'b1;
        if (cmd.del) count_nxt = count_r - 1'b1;
      end
      S_ROT:  if (step_r + 1'b1 >= count_r || count_r == '0) state_nxt = S_FL1;
      S_FL1:  state_nxt = S_FL2;
      S_FL2:  state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Division by ten through a reciprocal multiply, exact for every count the
  // row can hold.
  logic [CB+3:0]  nine_n;
  logic [CB+19:0] lo_prod, hi_prod;
  assign nine_n  = (CB+4)'({count_nxt, 3'b000}) + (CB+4)'(count_nxt);
  assign lo_prod = (CB+20)'(count_nxt) * (CB+20)'(DIV10_MUL);
  assign hi_prod = (CB+20)'(nine_n) * (CB+20)'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r  <= in_opcode;
      val_r <= in_value;
    end
    if (state_r == S_UPD) begin
      step_r <= '0;
      lo_r   <= CB'(lo_prod >> DIV10_SHIFT);
      hi_r   <= CB'(hi_prod >> DIV10_SHIFT);
      if (op_r == swts_pkg::OP_INSERT) begin
        status_r <= full ? swts_pkg::ST_FULL : swts_pkg::ST_DONE;
        pos_r    <= full ? '0 : ins_pos;
      end else begin
        status_r <= del_hit ? swts_pkg::ST_DONE : swts_pkg::ST_NOT_FOUND;
        pos_r    <= del_hit ? del_pos : '0;
      end
    end else if (rot) begin
      step_r <= step_r + 1'b1;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign busy            = state_r != S_IDLE;
  assign out_strobe      = state_r == S_OUT;
  assign out_status      = status_r;
  assign out_position    = swts_pkg::POS_BITS'(pos_r);
  assign out_entry_total = swts_pkg::TOTAL_BITS'(count_r);
  assign out_kept_total  = swts_pkg::KEPT_BITS'(hi_r - lo_r);
endmodule

/* src/swts_cell.sv */
// One slot of the sorted row. It knows its neighbors' values and flags and
// decides locally whether to keep, take the new value, or shift.
module swts_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swts_pkg::swts_cmd_t   cmd,
  input  logic [VALUE_BITS-1:0] op_value,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic                  left_mark,
  input  logic [VALUE_BITS-1:0] right_value,
  input  logic                  right_valid,
  input  logic                  mark,
  input  logic                  sum_en,
  input  logic [VALUE_BITS-1:0] sum_in,
  output logic [VALUE_BITS-1:0] value_r,
  output logic                  valid_r,
  output logic [VALUE_BITS-1:0] sum_out
);
  logic [VALUE_BITS-1:0] value_nxt;
  logic                  valid_nxt;

  // mark: this slot lies in the range the operation writes or shifts.
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (cmd.ins && mark) begin
      value_nxt = left_mark ? left_value : op_value;
      valid_nxt = 1'b1;
    end else if (cmd.del && mark) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign sum_out = sum_en ? sum_in : value_r;
endmodule

/* src/swts_stats.sv */
// Sum and square-sum accumulator: the row rotates its values toward slot zero,
// so one value arrives at the head per cycle; values flagged by take are squared and added.
module swts_stats #(
  parameter int VALUE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            clear,
  input  logic                            take,
  input  logic [VALUE_BITS-1:0]           head,
  output logic [swts_pkg::SUM_BITS-1:0]   sum_r,
  output logic [swts_pkg::SQ_BITS-1:0]    sq_r
);
  logic [2*VALUE_BITS-1:0] sqv_r;
  logic [VALUE_BITS-1:0]   v_r;
  logic                    take_r;

  always_ff @(posedge clk) begin
    v_r    <= head;
    sqv_r  <= (2*VALUE_BITS)'(head) * (2*VALUE_BITS)'(head);
    take_r <= clear ? 1'b0 : take;
    if (clear) begin
      sum_r  <= '0;
      sq_r   <= '0;
    end else if (take_r) begin
      sum_r <= sum_r + swts_pkg::SUM_BITS'(v_r);
      sq_r  <= sq_r + swts_pkg::SQ_BITS'(sqv_r);
    end
  end
endmodule
